// ===== hdl/olt_pkg.sv =====
`default_nettype none
package olt_pkg;

   localparam int LIST_DEPTH     = 16;
   localparam int RSP_FIFO_DEPTH = 4;

   localparam int FUNC_W = 3;
   localparam int DATA_W = 32;
   localparam int STAT_W = 2;
   localparam int POS_W  = 5;

   localparam int REQ_TDATA_W = ((DATA_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = POS_W + DATA_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
   localparam logic [FUNC_W-1:0] FN_SEARCH    = 3'd2;
   localparam logic [FUNC_W-1:0] FN_REMOVE    = 3'd3;
   localparam logic [FUNC_W-1:0] FN_DUMP_FWD  = 3'd4;
   localparam logic [FUNC_W-1:0] FN_DUMP_BWD  = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  position;
      logic [DATA_W-1:0] element;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic    push;
      rsp_type data;
   } rsp_push_type;

endpackage
`default_nettype wire

// ===== hdl/ordered_list_table_core.sv =====
`default_nettype none
// Channel  Dir  Handshake              tdata (low bit up)              tuser       tlast
// req      in   req_tvalid/req_tready  value[31:0]                     func[2:0]   -
// rsp      out  rsp_tvalid/rsp_tready  position[4:0], element[36:5]    status[1:0] last
//
// One request at a time; insert back writes the store directly, while search, remove,
// insert front and the dumps walk the store through its registered read port; a dump
// passes on one entry a cycle while the response queue has room.
// A synchronous reset clears the count and control; the store itself is not cleared.
// A 4-entry response queue absorbs rsp_tready stalls; a dump halts its reads when
// the queue has no room.
module ordered_list_table_core #(
   parameter int DEPTH = olt_pkg::LIST_DEPTH
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire [olt_pkg::REQ_TDATA_W-1:0]     req_tdata,   // value[31:0]
   input  wire [olt_pkg::FUNC_W-1:0]          req_tuser,   // func[2:0]
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [olt_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // position[4:0], element[36:5]
   output logic [olt_pkg::STAT_W-1:0]         rsp_tuser,   // status[1:0]
   output logic                               rsp_tlast
);
   import olt_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int LW = $clog2(RSP_FIFO_DEPTH + 1);

   rsp_push_type      push;
   rsp_type           rsp;
   logic [LW-1:0]     fifo_level;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [DATA_W-1:0] rd_data;

   olt_ctrl #(
      .DEPTH    (DEPTH),
      .FIFO_DEP (RSP_FIFO_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_func   (req_tuser),
      .req_value  (req_tdata[DATA_W-1:0]),
      .fifo_level (fifo_level),
      .push       (push),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   olt_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   olt_rsp_fifo #(
      .DEPTH (RSP_FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_data  (rsp),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .level     (fifo_level)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp.element, rsp.position};
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last;

endmodule
`default_nettype wire

// ===== hdl/olt_ram.sv =====
`default_nettype none
module olt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire                     rd_en,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/olt_rsp_fifo.sv =====
`default_nettype none
module olt_rsp_fifo #(
   parameter int DEPTH = olt_pkg::RSP_FIFO_DEPTH
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire olt_pkg::rsp_push_type     push,
   output olt_pkg::rsp_type               out_data,
   output logic                           out_valid,
   input  wire                            out_ready,
   output logic [$clog2(DEPTH+1)-1:0]     level
);
   import olt_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH + 1);

   rsp_type         mem_ff [DEPTH];
   logic [PW-1:0]   wptr_ff, wptr_in;
   logic [PW-1:0]   rptr_ff, rptr_in;
   logic [LW-1:0]   level_ff, level_in;
   logic            pop;

   assign out_valid = (level_ff != '0);
   assign out_data  = mem_ff[rptr_ff];
   assign level     = level_ff;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      level_in = level_ff;
      if (push.push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push.push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push.push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         level_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         mem_ff[wptr_ff] <= push.data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.push |-> (level_ff < LW'(DEPTH)))
      else $error("response queue overflow");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LW'(DEPTH))
      else $error("response queue level out of range");

   a_level_step: assert property (@(posedge clock) disable iff (reset)
      (push.push && !pop) |=> (level_ff == $past(level_ff) + 1'b1))
      else $error("response queue level did not advance on push");

endmodule
`default_nettype wire

// ===== hdl/olt_ctrl.sv =====
`default_nettype none
module olt_ctrl #(
   parameter int DEPTH    = olt_pkg::LIST_DEPTH,
   parameter int FIFO_DEP = olt_pkg::RSP_FIFO_DEPTH
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire [olt_pkg::FUNC_W-1:0]        req_func,
   input  wire [olt_pkg::DATA_W-1:0]        req_value,
   input  wire [$clog2(FIFO_DEP+1)-1:0]     fifo_level,
   output olt_pkg::rsp_push_type            push,
   output logic                             wr_en,
   output logic [$clog2(DEPTH)-1:0]         wr_addr,
   output logic [olt_pkg::DATA_W-1:0]       wr_data,
   output logic                             rd_en,
   output logic [$clog2(DEPTH)-1:0]         rd_addr,
   input  wire [olt_pkg::DATA_W-1:0]        rd_data
);
   import olt_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = $clog2(FIFO_DEP + 1);

   localparam int SW = 3;
   localparam logic [SW-1:0] S_IDLE = 3'd0;
   localparam logic [SW-1:0] S_SRCH = 3'd1;
   localparam logic [SW-1:0] S_SHDN = 3'd2;
   localparam logic [SW-1:0] S_SHUP = 3'd3;
   localparam logic [SW-1:0] S_HEAD = 3'd4;
   localparam logic [SW-1:0] S_DUMP = 3'd5;
   localparam logic [SW-1:0] S_RESP = 3'd6;

   logic [SW-1:0]     state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     radr_ff, radr_in;
   logic              pend_ff, pend_in;
   logic              plast_ff, plast_in;
   logic              rm_ff, rm_in;
   logic              dir_ff, dir_in;
   logic [DATA_W-1:0] val_ff, val_in;
   rsp_type           res_ff, res_in;

   logic              full;
   logic              fwd_more;
   logic              dump_more;
   logic              credit;

   assign full      = (count_ff >= CW'(DEPTH));
   assign fwd_more  = (idx_ff < count_ff);
   assign dump_more = dir_ff ? (idx_ff != '0) : fwd_more;
   assign credit    = ((LW + 1)'(fifo_level) + (LW + 1)'(pend_ff)) < (LW + 1)'(FIFO_DEP);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      radr_in  = radr_ff;
      pend_in  = 1'b0;
      plast_in = 1'b0;
      rm_in    = rm_ff;
      dir_in   = dir_ff;
      val_in   = val_ff;
      res_in   = res_ff;
      rd_en    = 1'b0;
      rd_addr  = radr_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = val_ff;
      push     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               val_in = req_value;
               unique case (req_func) inside
                  FN_INS_FRONT: begin
                     if (full) begin
                        res_in   = '{ST_FULL, '0, '0, 1'b1};
                        state_in = S_RESP;
                     end else if (count_ff == '0) begin
                        state_in = S_HEAD;
                     end else begin
                        idx_in   = count_ff;
                        state_in = S_SHUP;
                     end
                  end
                  FN_INS_BACK: begin
                     if (full) begin
                        res_in = '{ST_FULL, '0, '0, 1'b1};
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = req_value;
                        count_in = count_ff + 1'b1;
                        res_in   = '{ST_OK, POS_W'(count_ff), req_value, 1'b1};
                     end
                     state_in = S_RESP;
                  end
                  FN_SEARCH, FN_REMOVE: begin
                     idx_in   = '0;
                     rm_in    = (req_func == FN_REMOVE);
                     state_in = S_SRCH;
                  end
                  FN_DUMP_FWD, FN_DUMP_BWD: begin
                     if (count_ff == '0) begin
                        res_in   = '{ST_EMPTY, '0, '0, 1'b1};
                        state_in = S_RESP;
                     end else begin
                        dir_in   = (req_func == FN_DUMP_BWD);
                        idx_in   = (req_func == FN_DUMP_BWD) ? count_ff : '0;
                        state_in = S_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SRCH: begin
            if (fwd_more) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff[AW-1:0];
               radr_in = idx_ff[AW-1:0];
               pend_in = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end
            if (pend_ff && (rd_data == val_ff)) begin
               res_in   = '{ST_OK, POS_W'(radr_ff), val_ff, 1'b1};
               state_in = rm_ff ? S_SHDN : S_RESP;
            end else if (!pend_ff && !fwd_more) begin
               res_in   = '{ST_NOT_FOUND, '0, '0, 1'b1};
               state_in = S_RESP;
            end
         end
         S_SHDN: begin
            // close the gap: entry i+1 moves to i
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = radr_ff - 1'b1;
               wr_data = rd_data;
            end
            if (fwd_more) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff[AW-1:0];
               radr_in = idx_ff[AW-1:0];
               pend_in = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end else if (!pend_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_RESP;
            end
         end
         S_SHUP: begin
            // open a slot at the front: entry i moves to i+1, back first
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = radr_ff + 1'b1;
               wr_data = rd_data;
            end
            if (idx_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff[AW-1:0] - 1'b1;
               radr_in = idx_ff[AW-1:0] - 1'b1;
               pend_in = 1'b1;
               idx_in  = idx_ff - 1'b1;
            end else if (!pend_ff) begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = val_ff;
            count_in = count_ff + 1'b1;
            res_in   = '{ST_OK, '0, val_ff, 1'b1};
            state_in = S_RESP;
         end
         S_DUMP: begin
            if (pend_ff) begin
               push.push = 1'b1;
               push.data = '{ST_OK, POS_W'(radr_ff), rd_data, plast_ff};
            end
            if (dump_more && credit) begin
               rd_en    = 1'b1;
               pend_in  = 1'b1;
               if (dir_ff) begin
                  rd_addr  = idx_ff[AW-1:0] - 1'b1;
                  radr_in  = idx_ff[AW-1:0] - 1'b1;
                  plast_in = (idx_ff == CW'(1));
                  idx_in   = idx_ff - 1'b1;
               end else begin
                  rd_addr  = idx_ff[AW-1:0];
                  radr_in  = idx_ff[AW-1:0];
                  plast_in = ((idx_ff + 1'b1) == count_ff);
                  idx_in   = idx_ff + 1'b1;
               end
            end else if (!dump_more && !pend_ff) begin
               state_in = S_IDLE;
            end
         end
         S_RESP: begin
            if (fifo_level < LW'(FIFO_DEP)) begin
               push.push = 1'b1;
               push.data = res_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
         plast_ff <= 1'b0;
         rm_ff    <= 1'b0;
         dir_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
         plast_ff <= plast_in;
         rm_ff    <= rm_in;
         dir_ff   <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      radr_ff <= radr_in;
      val_ff  <= val_in;
      res_ff  <= res_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff) ||
                count_ff == $past(count_ff) + 1'b1 ||
                count_ff == $past(count_ff) - 1'b1))
      else $error("element count jumped");

   a_write_in_list: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((CW + 1)'(wr_addr) <= (CW + 1)'(count_ff)))
      else $error("store written beyond list end");

   a_pend_busy: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff != S_IDLE))
      else $error("read in flight while idle");

endmodule
`default_nettype wire
